// ===== rtl/hst_pkg.sv =====
// ----------------------------------------------------------------------------
// hst_pkg
// Shared constants and divider request/response types for the hue sweep
// test pattern generator.
// ----------------------------------------------------------------------------
package hst_pkg;

	localparam int DIM_BITS = 12;
	localparam int CH_W     = 8;
	localparam int LVL_W    = 7;
	localparam int STEP_W   = 11;
	localparam int NUM_W    = 23;
	localparam int CFG_W    = 1;

	localparam logic [CFG_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_W-1:0] REG_HEIGHT = 1'b1;

	localparam logic [DIM_BITS-1:0] WIDTH_RST  = 12'd352;
	localparam logic [DIM_BITS-1:0] HEIGHT_RST = 12'd288;

	localparam logic [CH_W-1:0]   FULL_SCALE  = 8'd255;
	localparam logic [LVL_W-1:0]  LEVEL_SCALE = 7'd127;
	localparam logic [STEP_W-1:0] ZERO_STEP   = 11'd1530;

	typedef struct packed {
		logic                start;
		logic [NUM_W-1:0]    num;
		logic [DIM_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [NUM_W-1:0]    quot;
		logic [DIM_BITS-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/hst_div.sv =====
// ----------------------------------------------------------------------------
// hst_div
// Restoring divider, one quotient bit per cycle. A start reloads it at any
// time; done pulses for one cycle with quotient and remainder.
// ----------------------------------------------------------------------------
module hst_div (
	input  logic              clk,
	input  logic              arst_n,
	input  hst_pkg::div_req_t req,
	output hst_pkg::div_rsp_t rsp
);
	import hst_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]    quot_q;
	logic [DIM_BITS-1:0] rem_q;
	logic [DIM_BITS-1:0] den_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DIM_BITS:0]   trial;
	logic [DIM_BITS:0]   diff;
	logic                fits;

	always_comb begin
		trial = {rem_q, quot_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
		end
	end

	assign rsp = '{done: done_q, quot: quot_q, rem: rem_q};

endmodule

// ===== rtl/hue_sweep_test_pattern.sv =====
// ----------------------------------------------------------------------------
// hue_sweep_test_pattern
// Rainbow gradient test pattern, one RGB24 pixel per accepted word.
// ----------------------------------------------------------------------------
// Each accepted request word yields one pixel word, in raster order, at one
// pixel per clock while req_stall is low. Row levels and the per-pixel ramp
// steps are kept as running quotient and remainder, so the pixel path has only
// adds and compares. The exact step for the next row is prepared by a shared
// 23-bit restoring divider (one bit per cycle) while the current row runs; if
// the current row ends first, the next row waits at its first pixel until the
// step is ready. After reset and after every configuration write the block
// holds req_stall while the divider re-derives all step values from the new
// frame size.
module hue_sweep_test_pattern (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [hst_pkg::CFG_W-1:0]    cfg_index,
	input  logic [hst_pkg::DIM_BITS-1:0] cfg_data,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         restart,
	output logic                         pix_valid,
	input  logic                         pix_stall,
	output logic [hst_pkg::CH_W-1:0]     red_level,
	output logic [hst_pkg::CH_W-1:0]     green_level,
	output logic [hst_pkg::CH_W-1:0]     blue_level,
	output logic                         row_end,
	output logic                         frame_end
);
	import hst_pkg::*;

	typedef enum logic [2:0] {
		PH_G_UP   = 3'd1,
		PH_R_DOWN = 3'd2,
		PH_B_UP   = 3'd3,
		PH_G_DOWN = 3'd4,
		PH_R_UP   = 3'd5,
		PH_B_DOWN = 3'd6,
		PH_HOLD   = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_HSTEP,
		SEQ_WZERO,
		SEQ_CUR,
		SEQ_CNT,
		SEQ_TRK,
		SEQ_PEND
	} seq_t;

	function automatic logic [STEP_W-1:0] span6(input logic [LVL_W-1:0] lvl);
		logic [CH_W-1:0] sp;
		sp = FULL_SCALE - {lvl, 1'b0};
		return {1'b0, sp, 2'b00} + {2'b00, sp, 1'b0};
	endfunction

	// configuration and frame state
	logic [DIM_BITS-1:0] width_q, height_q;
	logic [DIM_BITS-1:0] row_q, col_q, cnt_q;
	phase_t              phase_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [CH_W-1:0]     red_q, green_q, blue_q;
	logic [STEP_W-1:0]   acc_q;
	logic [DIM_BITS-1:0] accr_q;
	seq_t                seq_q;
	logic                div_run_q;
	logic                pix_valid_q;

	// step tables and row tracker
	logic [LVL_W-1:0]    hstep_a_q;
	logic [DIM_BITS-1:0] hstep_b_q;
	logic [STEP_W-1:0]   zero_a_q, step_a_q, pend_a_q;
	logic [DIM_BITS-1:0] zero_b_q, step_b_q, pend_b_q;
	logic [LVL_W-1:0]    trk_lvl_q;
	logic [DIM_BITS-1:0] trk_rem_q;

	// result register
	logic [CH_W-1:0] red_out_q, green_out_q, blue_out_q;
	logic            row_end_q, frame_end_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [DIM_BITS-1:0] wd, hd, row_eff, col_eff, row_next, col_next, cnt_next;
	logic                row_start, zero_row, take, busy, cap;
	logic [LVL_W-1:0]    lvl_cur;
	logic [STEP_W-1:0]   sa, q_this, q_next, acc_next;
	logic [DIM_BITS-1:0] sb, r_this, r_next, accr_next;
	logic [DIM_BITS:0]   rsum;
	logic                carry, done, moving;
	logic [CH_W-1:0]     lo, hi, span, rise, fall, r0, g0, b0, r_n, g_n, b_n;
	phase_t              phase_cur, phase_next;
	logic                row_end_c, frame_end_c;
	logic [DIM_BITS:0]   tsum;
	logic                tcarry;
	logic [DIM_BITS-1:0] trem;
	logic [LVL_W+1:0]    tlvl_sum;
	logic [LVL_W-1:0]    tlvl, trk_lvl_next;
	logic [DIM_BITS-1:0] trk_rem_next;
	logic [DIM_BITS:0]   nr;
	logic [DIM_BITS+LVL_W-1:0] lvl_num;
	logic [NUM_W-1:0]    cnt_num;
	logic [STEP_W-1:0]   span6_cur;

	hst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// pixel path
	always_comb begin
		wd        = (width_q == '0) ? DIM_BITS'(1) : width_q;
		hd        = (height_q == '0) ? DIM_BITS'(1) : height_q;
		row_eff   = restart ? '0 : row_q;
		col_eff   = restart ? '0 : col_q;
		row_start = col_eff == '0;
		zero_row  = row_eff == '0;

		lvl_cur = row_start ? (zero_row ? '0 : trk_lvl_q) : lvl_q;
		sa      = row_start ? (zero_row ? zero_a_q : pend_a_q) : step_a_q;
		sb      = row_start ? (zero_row ? zero_b_q : pend_b_q) : step_b_q;

		lo   = {1'b0, lvl_cur};
		hi   = FULL_SCALE - lo;
		span = hi - lo;

		q_this    = row_start ? '0 : acc_q;
		r_this    = row_start ? '0 : accr_q;
		phase_cur = row_start ? PH_G_UP : phase_q;
		r0        = row_start ? hi : red_q;
		g0        = row_start ? lo : green_q;
		b0        = row_start ? lo : blue_q;

		done = q_this >= {3'b000, span};
		rise = done ? hi : lo + q_this[CH_W-1:0];
		fall = done ? lo : hi - q_this[CH_W-1:0];

		rsum   = {1'b0, r_this} + {1'b0, sb};
		carry  = rsum >= {1'b0, wd};
		r_next = carry ? DIM_BITS'(rsum - {1'b0, wd}) : rsum[DIM_BITS-1:0];
		q_next = q_this + sa + STEP_W'(carry);

		r_n    = r0;
		g_n    = g0;
		b_n    = b0;
		moving = 1'b1;
		case (phase_cur)
			PH_G_UP:   g_n = rise;
			PH_R_DOWN: r_n = fall;
			PH_B_UP:   b_n = rise;
			PH_G_DOWN: g_n = fall;
			PH_R_UP:   r_n = rise;
			PH_B_DOWN: b_n = fall;
			default:   moving = 1'b0;
		endcase

		phase_next = phase_cur;
		cnt_next   = row_start ? '0 : cnt_q;
		acc_next   = q_this;
		accr_next  = r_this;
		if (moving) begin
			if (done) begin
				phase_next = phase_t'(phase_cur + 3'd1);
				cnt_next   = '0;
				acc_next   = '0;
				accr_next  = '0;
			end else begin
				cnt_next  = cnt_next + 1'b1;
				acc_next  = q_next;
				accr_next = r_next;
			end
		end

		row_end_c   = (width_q == '0) || (col_eff >= width_q - 1'b1);
		frame_end_c = row_end_c && ((height_q == '0) || (row_eff >= height_q - 1'b1));
		row_next    = row_end_c ? (frame_end_c ? '0 : row_eff + 1'b1) : row_eff;
		col_next    = row_end_c ? '0 : col_eff + 1'b1;

		// advance the level tracker by one row
		tsum     = {1'b0, trk_rem_q} + {1'b0, hstep_b_q};
		tcarry   = (height_q != '0) && (tsum >= {1'b0, height_q});
		trem     = tcarry ? DIM_BITS'(tsum - {1'b0, height_q}) : tsum[DIM_BITS-1:0];
		tlvl_sum = {2'b00, trk_lvl_q} + {2'b00, hstep_a_q} + (LVL_W+2)'(tcarry);
		tlvl     = (tlvl_sum > {2'b00, LEVEL_SCALE}) ? LEVEL_SCALE : tlvl_sum[LVL_W-1:0];

		if (height_q == '0) begin
			trk_lvl_next = '0;
			trk_rem_next = '0;
		end else if (zero_row) begin
			trk_lvl_next = hstep_a_q;
			trk_rem_next = hstep_b_q;
		end else begin
			trk_lvl_next = tlvl;
			trk_rem_next = trem;
		end
	end

	// divider operands
	always_comb begin
		nr        = (col_q == '0) ? {1'b0, row_q} : {1'b0, row_q} + 1'b1;
		lvl_num   = {nr, 6'b0} + {nr, 6'b0} - {6'b0, nr};
		span6_cur = span6(lvl_q);
		cnt_num   = span6_cur * cnt_q;

		div_req.start = (seq_q != SEQ_IDLE) && !div_run_q;
		div_req.num   = '0;
		div_req.den   = wd;
		case (seq_q)
			SEQ_HSTEP: begin
				div_req.num = NUM_W'(LEVEL_SCALE);
				div_req.den = hd;
			end
			SEQ_WZERO: div_req.num = NUM_W'(ZERO_STEP);
			SEQ_CUR:   div_req.num = NUM_W'(span6_cur);
			SEQ_CNT:   div_req.num = cnt_num;
			SEQ_TRK: begin
				div_req.num = NUM_W'(lvl_num);
				div_req.den = hd;
			end
			SEQ_PEND:  div_req.num = NUM_W'(span6(trk_lvl_q));
			default:   div_req.num = '0;
		endcase
	end

	assign busy = ((seq_q != SEQ_IDLE) && (seq_q != SEQ_PEND))
		|| ((seq_q == SEQ_PEND) && (col_q == '0) && (row_q != '0));
	assign req_stall = busy || (pix_valid_q && pix_stall);
	assign take      = req_valid && !req_stall;
	assign cap       = div_run_q && div_rsp.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			phase_q     <= PH_G_UP;
			lvl_q       <= '0;
			red_q       <= FULL_SCALE;
			green_q     <= '0;
			blue_q      <= '0;
			acc_q       <= '0;
			accr_q      <= '0;
			seq_q       <= SEQ_HSTEP;
			div_run_q   <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_WIDTH:  width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			if (cap && (seq_q == SEQ_CNT)) begin
				acc_q  <= (div_rsp.quot[NUM_W-1:STEP_W] != '0) ? '1 : div_rsp.quot[STEP_W-1:0];
				accr_q <= div_rsp.rem;
			end

			if (cfg_write) begin
				seq_q     <= SEQ_HSTEP;
				div_run_q <= 1'b0;
			end else if (take && row_start) begin
				seq_q     <= SEQ_PEND;
				div_run_q <= 1'b0;
			end else if (seq_q != SEQ_IDLE) begin
				if (!div_run_q) begin
					div_run_q <= 1'b1;
				end else if (div_rsp.done) begin
					div_run_q <= 1'b0;
					case (seq_q)
						SEQ_HSTEP: seq_q <= SEQ_WZERO;
						SEQ_WZERO: seq_q <= SEQ_CUR;
						SEQ_CUR:   seq_q <= SEQ_CNT;
						SEQ_CNT:   seq_q <= SEQ_TRK;
						SEQ_TRK:   seq_q <= SEQ_PEND;
						default:   seq_q <= SEQ_IDLE;
					endcase
				end
			end

			if (take) begin
				row_q   <= row_next;
				col_q   <= col_next;
				cnt_q   <= cnt_next;
				phase_q <= phase_next;
				lvl_q   <= lvl_cur;
				red_q   <= r_n;
				green_q <= g_n;
				blue_q  <= b_n;
				acc_q   <= acc_next;
				accr_q  <= accr_next;
			end

			if (take) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			case (seq_q)
				SEQ_HSTEP: begin
					hstep_a_q <= div_rsp.quot[LVL_W-1:0];
					hstep_b_q <= div_rsp.rem;
				end
				SEQ_WZERO: begin
					zero_a_q <= div_rsp.quot[STEP_W-1:0];
					zero_b_q <= div_rsp.rem;
				end
				SEQ_CUR: begin
					step_a_q <= div_rsp.quot[STEP_W-1:0];
					step_b_q <= div_rsp.rem;
				end
				SEQ_TRK: begin
					if (height_q == '0) begin
						trk_lvl_q <= '0;
						trk_rem_q <= '0;
					end else begin
						trk_lvl_q <= (div_rsp.quot[NUM_W-1:LVL_W] != '0) ? LEVEL_SCALE
							: div_rsp.quot[LVL_W-1:0];
						trk_rem_q <= div_rsp.rem;
					end
				end
				SEQ_PEND: begin
					pend_a_q <= div_rsp.quot[STEP_W-1:0];
					pend_b_q <= div_rsp.rem;
				end
				default: ;
			endcase
		end

		if (take && row_start) begin
			step_a_q  <= sa;
			step_b_q  <= sb;
			trk_lvl_q <= trk_lvl_next;
			trk_rem_q <= trk_rem_next;
		end

		if (take) begin
			red_out_q   <= r_n;
			green_out_q <= g_n;
			blue_out_q  <= b_n;
			row_end_q   <= row_end_c;
			frame_end_q <= frame_end_c;
		end
	end

	assign pix_valid   = pix_valid_q;
	assign red_level   = red_out_q;
	assign green_level = green_out_q;
	assign blue_level  = blue_out_q;
	assign row_end     = row_end_q;
	assign frame_end   = frame_end_q;

endmodule

// ===== rtl/hst_checker.sv =====
// ----------------------------------------------------------------------------
// hst_checker
// Port-level checks for the hue sweep test pattern generator.
// ----------------------------------------------------------------------------
module hst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_write,
	input logic       req_stall,
	input logic       pix_valid,
	input logic       pix_stall,
	input logic [7:0] red_level,
	input logic [7:0] green_level,
	input logic [7:0] blue_level,
	input logic       row_end,
	input logic       frame_end
);
	logic [8:0] sum_rg, sum_rb, sum_gb;
	logic       pair_ok;

	assign sum_rg  = {1'b0, red_level} + {1'b0, green_level};
	assign sum_rb  = {1'b0, red_level} + {1'b0, blue_level};
	assign sum_gb  = {1'b0, green_level} + {1'b0, blue_level};
	assign pair_ok = (sum_rg == 9'd255) || (sum_rb == 9'd255) || (sum_gb == 9'd255);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(red_level)
			&& $stable(green_level) && $stable(blue_level) && $stable(row_end)
			&& $stable(frame_end))
		else $error("stalled pixel word changed");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && frame_end |-> row_end)
		else $error("frame end without row end");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> req_stall)
		else $error("request taken while step values rebuild");

	a_hi_lo: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pair_ok)
		else $error("no channel pair at high and low level");

endmodule

bind hue_sweep_test_pattern hst_checker u_hst_checker (.*);
